FILE: hdl/sat_pkg.sv
// shared constants, op and status codes, controller/datapath interface types
// for the shadowing association table; no dependencies
package sat_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int VALUE_WIDTH = 32;

    localparam int KEY_W      = 32;
    localparam int VALUE_IN_W = 32;
    localparam int FOUND_W    = 32;
    localparam int COUNT_W    = 7;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W   = CNT_W + 1;
    localparam int ENTRY_W = KEY_W + VALUE_WIDTH;

    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [CMP_W-1:0]  ONE_CMP   = CMP_W'(1);
    localparam logic [CMP_W-1:0]  TWO_CMP   = CMP_W'(2);
    localparam logic [ADDR_W-1:0] ADDR_ONE  = ADDR_W'(1);
    localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);

    localparam logic [FUNC_W-1:0] OP_SET   = 2'd0;
    localparam logic [FUNC_W-1:0] OP_GET   = 2'd1;
    localparam logic [FUNC_W-1:0] OP_ERASE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

    typedef struct packed {
        logic                capture;     // latch the search key
        logic                append;      // write new pair at the tail
        logic                scan_start;  // point at newest entry, read it
        logic                scan_next;   // step one entry older, read it
        logic                shift_start; // start close-up at match position
        logic                shift_wr;    // write read entry one place down
        logic                shift_adv;   // advance close-up, read next entry
        logic                count_dec;
        logic                res_load;
        logic                res_found;   // return the read value
        logic [STATUS_W-1:0] res_status;
    } sat_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic match;
        logic idx_zero;
        logic shift_more;  // idx + 1 < count
        logic shift_cont;  // idx + 2 < count
    } sat_stat_t;

    function automatic logic [VALUE_WIDTH-1:0] to_stored(input logic [VALUE_IN_W-1:0] v);
        return VALUE_WIDTH'(v);
    endfunction

    function automatic logic [FOUND_W-1:0] to_found(input logic [VALUE_WIDTH-1:0] v);
        return FOUND_W'(v);
    endfunction

    function automatic logic [COUNT_W-1:0] to_count_out(input logic [CNT_W-1:0] c);
        return COUNT_W'(c);
    endfunction

endpackage

FILE: hdl/shadowing_association_table_top.sv
// set and failed-set, unused code, get/erase on an empty table: result strobe in the cycle
//   after the accepting edge, busy stays low, so these can follow every cycle
// get/erase: one stored pair compared per cycle newest first through the ram read port;
//   result strobe when the scan ends, busy meanwhile
// erase then closes up, moving each newer pair one place down (count - 1 - match position)
// reset returns the sequencer to idle and clears the pair count; the pair memory has no reset
module shadowing_association_table_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [sat_pkg::FUNC_W-1:0]     func,
    input  logic [sat_pkg::KEY_W-1:0]      key,
    input  logic [sat_pkg::VALUE_IN_W-1:0] value,
    output logic                           done,
    output logic [sat_pkg::STATUS_W-1:0]   status,
    output logic [sat_pkg::FOUND_W-1:0]    found_value,
    output logic [sat_pkg::COUNT_W-1:0]    entry_count
);

    sat_pkg::sat_cmd_t  cmd;
    sat_pkg::sat_stat_t stat;

    sat_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    sat_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .key         (key),
        .value       (value),
        .stat        (stat),
        .status      (status),
        .found_value (found_value),
        .entry_count (entry_count)
    );

endmodule

FILE: hdl/sat_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module sat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/sat_ctrl.sv
// operation sequencer: newest-first scan, erase close-up, result strobe
// depends on sat_pkg
module sat_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sat_pkg::FUNC_W-1:0]    func,
    input  sat_pkg::sat_stat_t            stat,
    output sat_pkg::sat_cmd_t             cmd,
    output logic                          busy,
    output logic                          done
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [sat_pkg::FUNC_W-1:0] op_reg, op_next;
    logic                       done_reg, done_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        op_next    = op_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = func;
                    cmd.capture = 1'b1;
                    unique case (func) inside
                        sat_pkg::OP_SET:
                        begin
                            cmd.res_load = 1'b1;
                            done_next    = 1'b1;
                            if (stat.full)
                            begin
                                cmd.res_status = sat_pkg::STAT_FULL;
                            end
                            else
                            begin
                                cmd.append     = 1'b1;
                                cmd.res_status = sat_pkg::STAT_OK;
                            end
                        end
                        sat_pkg::OP_GET, sat_pkg::OP_ERASE:
                        begin
                            if (stat.empty)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = sat_pkg::STAT_NOT_FOUND;
                                done_next      = 1'b1;
                            end
                            else
                            begin
                                cmd.scan_start = 1'b1;
                                state_next     = S_CMP;
                            end
                        end
                        default:
                        begin
                            // unused code: no change, ok
                            cmd.res_load   = 1'b1;
                            cmd.res_status = sat_pkg::STAT_OK;
                            done_next      = 1'b1;
                        end
                    endcase
                end
            end
            S_CMP:
            begin
                if (stat.match)
                begin
                    if (op_reg == sat_pkg::OP_GET)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_found  = 1'b1;
                        cmd.res_status = sat_pkg::STAT_OK;
                        done_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else if (stat.shift_more)
                    begin
                        cmd.shift_start = 1'b1;
                        state_next      = S_SHIFT;
                    end
                    else
                    begin
                        // newest entry matched: just drop the tail
                        cmd.count_dec  = 1'b1;
                        cmd.res_load   = 1'b1;
                        cmd.res_status = sat_pkg::STAT_OK;
                        done_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (stat.idx_zero)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = sat_pkg::STAT_NOT_FOUND;
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_wr = 1'b1;
                if (stat.shift_cont)
                begin
                    cmd.shift_adv = 1'b1;
                end
                else
                begin
                    cmd.count_dec  = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = sat_pkg::STAT_OK;
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= sat_pkg::OP_SET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    a_no_strobe_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !done_reg)
        else $error("result strobe while an operation is in progress");

    a_shift_only_on_erase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (op_reg == sat_pkg::OP_ERASE))
        else $error("close-up running for an operation other than erase");

    a_scan_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (op_reg == sat_pkg::OP_GET || op_reg == sat_pkg::OP_ERASE))
        else $error("scan running for an operation other than get or erase");

endmodule

FILE: hdl/sat_dp.sv
// datapath: pair memory, pair count, scan index, key and result registers
// depends on sat_pkg and sat_ram
module sat_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sat_pkg::sat_cmd_t              cmd,
    input  logic [sat_pkg::KEY_W-1:0]      key,
    input  logic [sat_pkg::VALUE_IN_W-1:0] value,
    output sat_pkg::sat_stat_t             stat,
    output logic [sat_pkg::STATUS_W-1:0]   status,
    output logic [sat_pkg::FOUND_W-1:0]    found_value,
    output logic [sat_pkg::COUNT_W-1:0]    entry_count
);

    logic [sat_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [sat_pkg::ADDR_W-1:0]   idx_reg, idx_next;
    logic [sat_pkg::KEY_W-1:0]    key_reg;
    logic [sat_pkg::STATUS_W-1:0] status_reg;
    logic [sat_pkg::FOUND_W-1:0]  found_reg;

    logic                           ram_we;
    logic [sat_pkg::ADDR_W-1:0]     ram_waddr;
    logic [sat_pkg::ENTRY_W-1:0]    ram_wdata;
    logic                           ram_re;
    logic [sat_pkg::ADDR_W-1:0]     ram_raddr;
    logic [sat_pkg::ENTRY_W-1:0]    ram_rdata;

    logic [sat_pkg::KEY_W-1:0]       rd_key;
    logic [sat_pkg::VALUE_WIDTH-1:0] rd_val;
    logic [sat_pkg::CNT_W-1:0]       count_m1;
    logic [sat_pkg::ADDR_W-1:0]      idx_m1;
    logic [sat_pkg::CMP_W-1:0]       count_ext;
    logic [sat_pkg::CMP_W-1:0]       idx_ext;
    logic [sat_pkg::CMP_W-1:0]       idx_p1;
    logic [sat_pkg::CMP_W-1:0]       idx_p2;

    // entry layout: key in the upper bits, value below
    assign rd_key = ram_rdata[sat_pkg::ENTRY_W-1 -: sat_pkg::KEY_W];
    assign rd_val = ram_rdata[sat_pkg::VALUE_WIDTH-1:0];

    assign count_m1  = count_reg - sat_pkg::CNT_ONE;
    assign idx_m1    = idx_reg - sat_pkg::ADDR_ONE;
    assign count_ext = {1'b0, count_reg};
    assign idx_ext   = {{(sat_pkg::CMP_W - sat_pkg::ADDR_W){1'b0}}, idx_reg};
    assign idx_p1    = idx_ext + sat_pkg::ONE_CMP;
    assign idx_p2    = idx_ext + sat_pkg::TWO_CMP;

    assign stat.full       = (count_reg >= sat_pkg::DEPTH_CNT);
    assign stat.empty      = (count_reg == '0);
    assign stat.match      = (rd_key == key_reg);
    assign stat.idx_zero   = (idx_reg == '0);
    assign stat.shift_more = (idx_p1 < count_ext);
    assign stat.shift_cont = (idx_p2 < count_ext);

    // write port: append at the tail, or close-up one place down
    assign ram_we    = cmd.append | cmd.shift_wr;
    assign ram_waddr = cmd.append ? count_reg[sat_pkg::ADDR_W-1:0] : idx_reg;
    assign ram_wdata = cmd.append ? {key, sat_pkg::to_stored(value)} : ram_rdata;

    assign ram_re = cmd.scan_start | cmd.scan_next | cmd.shift_start | cmd.shift_adv;

    always_comb
    begin
        ram_raddr = idx_reg;
        idx_next  = idx_reg;
        if (cmd.scan_start)
        begin
            ram_raddr = count_m1[sat_pkg::ADDR_W-1:0];
            idx_next  = count_m1[sat_pkg::ADDR_W-1:0];
        end
        else if (cmd.scan_next)
        begin
            ram_raddr = idx_m1;
            idx_next  = idx_m1;
        end
        else if (cmd.shift_start)
        begin
            ram_raddr = idx_p1[sat_pkg::ADDR_W-1:0];
        end
        else if (cmd.shift_adv)
        begin
            ram_raddr = idx_p2[sat_pkg::ADDR_W-1:0];
            idx_next  = idx_p1[sat_pkg::ADDR_W-1:0];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.append)
        begin
            count_next = count_reg + sat_pkg::CNT_ONE;
        end
        else if (cmd.count_dec)
        begin
            count_next = count_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg <= key;
        end
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_status;
            found_reg  <= cmd.res_found ? sat_pkg::to_found(rd_val) : '0;
        end
    end

    sat_ram #(
        .WIDTH (sat_pkg::ENTRY_W),
        .DEPTH (sat_pkg::TABLE_DEPTH)
    ) u_pair_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign status      = status_reg;
    assign found_value = found_reg;
    assign entry_count = sat_pkg::to_count_out(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sat_pkg::DEPTH_CNT)
        else $error("pair count above table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (count_reg == $past(count_reg) || count_reg == $past(count_reg) + sat_pkg::CNT_ONE
             || count_reg == $past(count_reg) - sat_pkg::CNT_ONE))
        else $error("pair count moved by more than one");

    a_append_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> !stat.full)
        else $error("append on a full table");

endmodule
